### src/md2_pkg.sv
// md2_pkg: shared types, constants and the MD2 substitution table.
// Used by every module of the MD2 engine.
package md2_pkg;

	typedef enum logic {
		KIND_APPEND = 1'b0,
		KIND_FINISH = 1'b1
	} item_kind_t;

	typedef struct packed {
		item_kind_t  kind;
		logic [7:0]  data;
	} md2_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_COMP,
		ST_EMIT0,
		ST_EMIT1
	} back_state_t;

	localparam int BLOCK_BYTES = 16;
	localparam int WORK_BYTES  = 48;
	localparam logic [5:0] LAST_IDX = 6'd47;
	localparam logic [4:0] LAST_RND = 5'd17;
	localparam logic [3:0] LAST_FILL = 4'd15;
	localparam logic [4:0] PAD_BASE = 5'd16;

	localparam logic [7:0] SBOX [256] = '{
		8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
		8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
		8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
		8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
		8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
		8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
		8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
		8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
		8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
		8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
		8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
		8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
		8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
		8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
		8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
		8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
		8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
		8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
		8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
		8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
		8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
		8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
		8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
		8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
		8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
		8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
		8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
		8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
		8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
		8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
		8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
		8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
	};

endpackage

### src/md2_in_if.sv
// md2_in_if: input channel of the MD2 engine (valid/ready plus one item).
// Depends on nothing.
interface md2_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

### src/md2_out_if.sv
// md2_out_if: result channel of the MD2 engine (valid/ready plus one digest word).
// Depends on nothing.
interface md2_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_word;
	logic        last_word;

	modport source (output valid, output digest_word, output last_word, input ready);
	modport sink   (input valid, input digest_word, input last_word, output ready);
endinterface

### src/md2_front.sv
// md2_front: accepts input items, classifies them and queues them for the back end.
// Depends on md2_pkg and md2_in_if.
module md2_front #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	md2_in_if.sink              req,
	output md2_pkg::md2_item_t  item,
	output logic                item_valid,
	input  logic                item_pop
);
	import md2_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	md2_item_t     mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;
	md2_item_t     in_item;

	assign req.ready  = (count_q != CNT_FULL);
	assign push       = req.valid && req.ready;
	assign item_valid = (count_q != '0);
	assign pop        = item_pop && item_valid;
	assign item       = mem_q[rd_ptr_q];

	always_comb begin
		in_item.kind = req.kind ? KIND_FINISH : KIND_APPEND;
		in_item.data = req.data_byte;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

### src/md2_back.sv
// md2_back: block gathering, serial MD2 compression, checksum and digest output.
// Depends on md2_pkg and md2_out_if.
module md2_back (
	input  logic                clk,
	input  logic                arst_n,
	input  md2_pkg::md2_item_t  item,
	input  logic                item_valid,
	output logic                item_pop,
	md2_out_if.source           rsp
);
	import md2_pkg::*;

	back_state_t state_q;
	back_state_t state_nxt;

	logic [7:0] work_q  [WORK_BYTES];
	logic [7:0] chain_q [BLOCK_BYTES];
	logic [7:0] sum_q   [BLOCK_BYTES];
	logic [7:0] buf_q   [BLOCK_BYTES];
	logic [3:0] fill_q;
	logic [5:0] idx_q;
	logic [4:0] rnd_q;
	logic [7:0] t_q;
	logic [7:0] prev_q;
	logic       fin_q;
	logic       final_q;

	logic [7:0] new_byte;
	logic [7:0] sum_new;
	logic [7:0] pad_byte;
	logic       comp_done;
	logic       sum_step;
	logic       take;
	logic [7:0] blk [BLOCK_BYTES];

	assign new_byte  = work_q[0] ^ SBOX[t_q];
	assign sum_new   = sum_q[idx_q[3:0]] ^ SBOX[buf_q[idx_q[3:0]] ^ prev_q];
	assign pad_byte  = {3'b000, PAD_BASE - {1'b0, fill_q}};
	assign comp_done = (state_q == ST_COMP) && (idx_q == LAST_IDX) && (rnd_q == LAST_RND);
	assign sum_step  = (state_q == ST_COMP) && !final_q && (rnd_q == '0) && !idx_q[5]
		&& !idx_q[4];
	assign take      = item_valid && item_pop;

	always_comb begin
		for (int j = 0; j < BLOCK_BYTES; j++) begin
			blk[j] = final_q ? sum_q[j] : buf_q[j];
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (item.kind == KIND_FINISH || fill_q == LAST_FILL) begin
						state_nxt = ST_LOAD;
					end
				end
			end
			ST_LOAD:  state_nxt = ST_COMP;
			ST_COMP: begin
				if (comp_done) begin
					if (final_q) begin
						state_nxt = ST_EMIT0;
					end else if (fin_q) begin
						state_nxt = ST_LOAD;
					end else begin
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_EMIT0: if (rsp.ready) state_nxt = ST_EMIT1;
			ST_EMIT1: if (rsp.ready) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		item_pop        = 1'b0;
		rsp.valid       = 1'b0;
		rsp.last_word   = 1'b0;
		rsp.digest_word = '0;
		case (state_q)
			ST_IDLE:  item_pop = 1'b1;
			ST_EMIT0: begin
				rsp.valid = 1'b1;
				for (int j = 0; j < 8; j++) begin
					rsp.digest_word[63-8*j -: 8] = chain_q[j];
				end
			end
			ST_EMIT1: begin
				rsp.valid     = 1'b1;
				rsp.last_word = 1'b1;
				for (int j = 0; j < 8; j++) begin
					rsp.digest_word[63-8*j -: 8] = chain_q[8+j];
				end
			end
			default: item_pop = 1'b0;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && take) begin
			if (item.kind == KIND_APPEND) begin
				buf_q[fill_q] <= item.data;
			end else begin
				for (int j = 0; j < BLOCK_BYTES; j++) begin
					if (4'(j) >= fill_q) begin
						buf_q[j] <= pad_byte;
					end
				end
			end
		end
		if (state_q == ST_LOAD) begin
			t_q <= '0;
			for (int j = 0; j < BLOCK_BYTES; j++) begin
				work_q[j]                 <= chain_q[j];
				work_q[BLOCK_BYTES+j]     <= blk[j];
				work_q[2*BLOCK_BYTES+j]   <= chain_q[j] ^ blk[j];
			end
		end else if (state_q == ST_COMP) begin
			for (int j = 0; j < WORK_BYTES - 1; j++) begin
				work_q[j] <= work_q[j+1];
			end
			work_q[WORK_BYTES-1] <= new_byte;
			t_q <= (idx_q == LAST_IDX) ? new_byte + {3'b000, rnd_q} : new_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			idx_q   <= '0;
			rnd_q   <= '0;
			prev_q  <= '0;
			fin_q   <= 1'b0;
			final_q <= 1'b0;
			for (int j = 0; j < BLOCK_BYTES; j++) begin
				chain_q[j] <= '0;
				sum_q[j]   <= '0;
			end
		end else begin
			state_q <= state_nxt;
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (item.kind == KIND_APPEND) begin
							fill_q <= fill_q + 1'b1;
						end else begin
							fin_q <= 1'b1;
						end
					end
				end
				ST_LOAD: begin
					idx_q  <= '0;
					rnd_q  <= '0;
					prev_q <= sum_q[BLOCK_BYTES-1];
				end
				ST_COMP: begin
					if (idx_q == LAST_IDX) begin
						idx_q <= '0;
						rnd_q <= rnd_q + 1'b1;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
					if (sum_step) begin
						sum_q[idx_q[3:0]] <= sum_new;
						prev_q            <= sum_new;
					end
					if (comp_done) begin
						for (int j = 0; j < BLOCK_BYTES; j++) begin
							chain_q[j] <= work_q[j+1];
						end
						if (fin_q) begin
							final_q <= 1'b1;
						end
					end
				end
				ST_EMIT1: begin
					if (rsp.ready) begin
						fill_q  <= '0;
						fin_q   <= 1'b0;
						final_q <= 1'b0;
						for (int j = 0; j < BLOCK_BYTES; j++) begin
							chain_q[j] <= '0;
							sum_q[j]   <= '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end
endmodule

### src/md2_hash_engine_core.sv
// md2_hash_engine_core: MD2 message digest engine, top level.
// Depends on md2_pkg, md2_in_if, md2_out_if, md2_front and md2_back.
//
// Usage: items arrive on req (valid/ready). kind 0 appends data_byte to the
// message, kind 1 finishes it. A finish gives two items on rsp: the first eight
// digest bytes (first byte in the top bits), then the last eight with
// last_word set. The engine is then cleared for the next message.
// An append that does not close a 16-byte block is only stored in the block
// buffer. The sixteenth byte of a block is taken, the work line is loaded,
// then the block is compressed with one substitution-table lookup per cycle
// over the 48-byte work shift line, 18 rounds of 48 steps; the checksum is
// updated in the first 16 steps. A finish pads the block and compresses it,
// then loads and compresses the checksum as a last block, then gives the two
// words. The core takes no new item until it is through with the block.
// A queue of QUEUE_DEPTH items in front keeps req ready while it has room.
// When the receiver stalls, the current word holds on rsp and the core waits;
// req stays ready until the queue fills.
// Reset clears the chaining state, checksum, fill count and queue at once.
module md2_hash_engine_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	md2_in_if.sink     req,
	md2_out_if.source  rsp
);
	import md2_pkg::*;

	md2_item_t q_item;
	logic      q_valid;
	logic      q_pop;

	md2_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.item       (q_item),
		.item_valid (q_valid),
		.item_pop   (q_pop)
	);

	md2_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (q_item),
		.item_valid (q_valid),
		.item_pop   (q_pop),
		.rsp        (rsp)
	);
endmodule

### test/md2_digest_sb_pkg.sv
// md2_digest_sb_pkg: digest predictor and result checker for the MD2 engine bench.
// Depends on md2_pkg (item kinds and the substitution table).
package md2_digest_sb_pkg;
	import md2_pkg::*;

	typedef struct packed {
		logic [63:0] digest_word;
		logic        last_word;
	} digest_beat_t;

	class md2_digest_sb;
		logic [7:0]   chain [16];
		logic [7:0]   csum [16];
		logic [7:0]   blk [16];
		logic [3:0]   fill;
		digest_beat_t digest_q [$];
		int           errors;

		function new();
			errors = 0;
			foreach (blk[i]) blk[i] = '0;
			clear_message();
		endfunction

		function void clear_message();
			foreach (chain[i]) begin
				chain[i] = '0;
				csum[i] = '0;
			end
			fill = '0;
		endfunction

		// One block through the 18-round compression, checksum updated alongside.
		function void compress_block(input logic [7:0] m [16]);
			logic [7:0] w [48];
			logic [7:0] t;
			logic [7:0] prev;
			for (int i = 0; i < 16; i++) begin
				w[i] = chain[i];
				w[16 + i] = m[i];
				w[32 + i] = chain[i] ^ m[i];
			end
			t = '0;
			for (int r = 0; r < 18; r++) begin
				for (int i = 0; i < 48; i++) begin
					w[i] = w[i] ^ SBOX[t];
					t = w[i];
				end
				t = t + 8'(r);
			end
			prev = csum[15];
			for (int i = 0; i < 16; i++) begin
				csum[i] = csum[i] ^ SBOX[m[i] ^ prev];
				prev = csum[i];
			end
			for (int i = 0; i < 16; i++) chain[i] = w[i];
		endfunction

		function void note_item(input item_kind_t kind, input logic [7:0] data_byte);
			logic [7:0]   sum_copy [16];
			logic [63:0]  hi;
			logic [63:0]  lo;
			digest_beat_t beat;
			if (kind == KIND_APPEND) begin
				blk[fill] = data_byte;
				fill = fill + 4'd1;
				if (fill == 4'd0)
					compress_block(blk);
				return;
			end
			for (int i = int'(fill); i < 16; i++) blk[i] = 8'(16 - int'(fill));
			compress_block(blk);
			sum_copy = csum;
			compress_block(sum_copy);
			hi = '0;
			lo = '0;
			for (int i = 0; i < 8; i++) begin
				hi = {hi[55:0], chain[i]};
				lo = {lo[55:0], chain[8 + i]};
			end
			beat.digest_word = hi;
			beat.last_word = 1'b0;
			digest_q.push_back(beat);
			beat.digest_word = lo;
			beat.last_word = 1'b1;
			digest_q.push_back(beat);
			clear_message();
		endfunction

		function void check_word(input logic [63:0] digest_word, input logic last_word,
				input realtime stamp);
			digest_beat_t exp_beat;
			if (digest_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected digest word, expected none, actual %h last %b",
					stamp, digest_word, last_word);
				return;
			end
			exp_beat = digest_q.pop_front();
			if (digest_word !== exp_beat.digest_word) begin
				errors++;
				$display("%0t: digest_word mismatch, expected %h, actual %h",
					stamp, exp_beat.digest_word, digest_word);
			end
			if (last_word !== exp_beat.last_word) begin
				errors++;
				$display("%0t: last_word mismatch, expected %b, actual %b",
					stamp, exp_beat.last_word, last_word);
			end
		endfunction

		function int words_due();
			return digest_q.size();
		endfunction
	endclass

endpackage

### test/md2_hash_engine_core_tb.sv
// md2_hash_engine_core_tb: drives byte and finish items into the MD2 engine and
// checks every digest word against the predictor in md2_digest_sb_pkg.
// Depends on md2_pkg, md2_in_if, md2_out_if, md2_digest_sb_pkg and md2_hash_engine_core.
module md2_hash_engine_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import md2_pkg::*;
	import md2_digest_sb_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	bit   in_throttle;
	bit   out_throttle;
	int   rand_items;
	int   rand_msgs;

	md2_digest_sb sb;

	md2_in_if  req_ch ();
	md2_out_if rsp_ch ();

	md2_hash_engine_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic send_item(input item_kind_t kind, input logic [7:0] data_byte);
		int gap;
		gap = in_throttle ? $urandom_range(0, 9) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= kind;
		req_ch.data_byte <= data_byte;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sb.note_item(kind, data_byte);
	endtask

	task automatic wait_digests_done();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (sb.words_due() != 0) @(posedge clk);
	endtask

	// mode 0: random bytes, 1: all zero, 2: all ones
	task automatic send_message(input int len, input int mode);
		logic [7:0] b;
		for (int n = 0; n < len; n++) begin
			case (mode)
				1: b = 8'h00;
				2: b = 8'hff;
				default: b = 8'($urandom);
			endcase
			send_item(KIND_APPEND, b);
		end
		send_item(KIND_FINISH, 8'($urandom));
	endtask

	// result side
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = out_throttle ? $urandom_range(0, 9) : 0;
			@(negedge clk);
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			sb.check_word(rsp_ch.digest_word, rsp_ch.last_word, $realtime);
		end
	end

	// watchdog: cycles in a row with no item moving on either channel
	initial begin
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		int len;
		int mode;
		sb = new();
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_APPEND;
		req_ch.data_byte = 8'h00;
		rsp_ch.ready = 1'b0;
		in_throttle = 1'b1;
		out_throttle = 1'b1;
		rand_items = 0;
		rand_msgs = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// empty messages back to back, one byte, one exact block
		send_item(KIND_FINISH, 8'ha5);
		send_item(KIND_FINISH, 8'h00);
		send_item(KIND_APPEND, 8'hff);
		send_item(KIND_FINISH, 8'hff);
		for (int n = 0; n < 16; n++)
			send_item(KIND_APPEND, n[0] ? 8'hff : 8'h00);
		send_item(KIND_FINISH, 8'h5a);
		wait_digests_done();

		while (rand_items < 900 || rand_msgs < 30) begin
			if ($urandom_range(0, 7) == 0) begin
				in_throttle = 1'($urandom_range(0, 1));
				out_throttle = 1'($urandom_range(0, 1));
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: len = $urandom_range(0, 20);
				6, 7: len = $urandom_range(14, 18);
				8: len = $urandom_range(30, 33);
				default: len = $urandom_range(33, 64);
			endcase
			case ($urandom_range(0, 9))
				0: mode = 1;
				1: mode = 2;
				default: mode = 0;
			endcase
			send_message(len, mode);
			rand_items += len + 1;
			rand_msgs++;
			if ($urandom_range(0, 5) == 0)
				wait_digests_done();
		end

		wait_digests_done();
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.words_due() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
